@@ sv/key_state_tracker_multitap_unit_defines.svh @@
// Assertion macros for the key state tracker.
// Included by the top level; depends on nothing else.
`ifndef KEY_STATE_TRACKER_MULTITAP_UNIT_DEFINES_SVH
`define KEY_STATE_TRACKER_MULTITAP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KSTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KSTM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kstm_pkg.sv @@
// Shared constants, types and codes of the key state tracker.
// Used by kstm_table and key_state_tracker_multitap_unit; depends on nothing.
package kstm_pkg;

  localparam int NUM_KEYS     = 256;
  localparam int MAX_PRESSED  = 16;
  localparam int MAX_RELEASED = 16;
  localparam int TIME_BITS    = 32;

  localparam int MODE_W    = 2;
  localparam int KEY_W     = 8;
  localparam int TREQ_W    = 32;
  localparam int WIN_W     = 32;
  localparam int TAP_W     = 8;
  localparam int CNT_OUT_W = 5;

  localparam int KIW   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int PCW   = $clog2(MAX_PRESSED + 1);
  localparam int RCW   = $clog2(MAX_RELEASED + 1);
  localparam int PLW   = (MAX_PRESSED > 1) ? $clog2(MAX_PRESSED) : 1;
  localparam int RLW   = (MAX_RELEASED > 1) ? $clog2(MAX_RELEASED) : 1;
  localparam int WKW0  = (PCW > RCW) ? PCW : RCW;
  localparam int WKW   = (KIW > WKW0) ? KIW : WKW0;
  localparam int CMP_W = (TIME_BITS > WIN_W) ? TIME_BITS : WIN_W;

  localparam int IN_W      = KEY_W + TREQ_W;
  localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
  localparam int OUT_W     = TAP_W + 4 + 2 * CNT_OUT_W;
  localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-3:0] REG_COMBO_WINDOW = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_FRAME   = 2'd2,
    MODE_QUERY   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_OUT,
    S_CLR_P,
    S_CLR_R,
    S_CLR_ALL,
    S_FRD
  } state_e;

  typedef struct packed {
    logic released;
    logic pressed;
  } evt_t;

  typedef struct packed {
    logic                 down;
    logic                 up;
    logic [TAP_W-1:0]     tap;
    logic [TIME_BITS-1:0] last;
  } hold_t;

  typedef struct packed {
    logic           re;
    logic [KIW-1:0] raddr;
    logic [KIW-1:0] waddr;
    evt_t           evt_we;
    evt_t           evt_wd;
    logic           hold_we;
    hold_t          hold_wd;
    logic           vld_set;
  } tbl_req_t;

  typedef struct packed {
    evt_t  evt;
    hold_t hold;
  } tbl_rsp_t;

endpackage

@@ sv/kstm_table.sv @@
// Per-key state table: frame flags and held state in two synchronous memories.
// Entries never written read as zero through one valid bit per key. Uses kstm_pkg.
module kstm_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kstm_pkg::tbl_req_t req_i,
  output kstm_pkg::tbl_rsp_t rsp_o
);
  import kstm_pkg::*;

  evt_t              evt_mem  [NUM_KEYS];
  hold_t             hold_mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] vld_q;
  evt_t              evt_rd_q;
  hold_t             hold_rd_q;
  logic              vld_rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.evt_we.pressed) begin
      evt_mem[req_i.waddr].pressed <= req_i.evt_wd.pressed;
    end
    if (req_i.evt_we.released) begin
      evt_mem[req_i.waddr].released <= req_i.evt_wd.released;
    end
    if (req_i.hold_we) begin
      hold_mem[req_i.waddr] <= req_i.hold_wd;
    end
    if (req_i.re) begin
      evt_rd_q  <= evt_mem[req_i.raddr];
      hold_rd_q <= hold_mem[req_i.raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (req_i.vld_set) begin
        vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        vld_rd_q <= vld_q[req_i.raddr];
      end
    end
  end

  assign rsp_o.evt  = vld_rd_q ? evt_rd_q : '0;
  assign rsp_o.hold = vld_rd_q ? hold_rd_q : '0;

endmodule

@@ sv/key_state_tracker_multitap_unit.sv @@
// Top level of the key state tracker: beat handshakes, APB register and sequencer.
// Depends on kstm_pkg, kstm_table and key_state_tracker_multitap_unit_defines.svh.
//
//  channel   direction  ports                       beat contents
//  s_axis    in         tvalid tready tdata tuser   mode in tuser; key, time_req in tdata
//  m_axis    out        tvalid tready tdata         combo, four flags, both log counts
//  apb       in/out     psel penable pwrite paddr   combo_window at byte address 0
//
// Press, release and query each go through the table memory read, the read-modify-write
// that follows it and the output register. An end of frame clears the logged keys one by
// one, or sweeps all NUM_KEYS entries when a log filled up, then reports the key.
// Reset clears the table through per-key valid bits, so no clearing pass is needed.
// A stalled result waits in the output register; the sequencer holds until it leaves.
`include "key_state_tracker_multitap_unit_defines.svh"

module key_state_tracker_multitap_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [7:0] key, [39:8] time_req
  input  logic [kstm_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // [1:0] mode
  input  logic [kstm_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [7:0] combo, [8] pressed, [9] released, [10] down, [11] up,
  // [16:12] pressed_count, [21:17] released_count, [23:22] zero
  output logic [kstm_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kstm_pkg::APB_AW-1:0]       paddr,
  input  logic [kstm_pkg::APB_DW-1:0]       pwdata,
  output logic [kstm_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import kstm_pkg::*;

  state_e               st_q, st_d;
  mode_e                mode_q;
  logic [KEY_W-1:0]     key_q;
  logic [TIME_BITS-1:0] time_q;
  logic [WIN_W-1:0]     win_q;
  logic [KEY_W-1:0]     plog_q [MAX_PRESSED];
  logic [KEY_W-1:0]     rlog_q [MAX_RELEASED];
  logic [PCW-1:0]       ptot_q, ptot_d;
  logic [RCW-1:0]       rtot_q, rtot_d;
  logic [WKW-1:0]       wk_q, wk_d;
  logic [OUT_W-1:0]     res_q, res_d;
  logic [OUT_W-1:0]     m_data_q;
  logic                 m_valid_q;
  logic                 m_load;
  logic                 plog_we;
  logic                 rlog_we;
  logic                 s_acc;
  logic                 apb_hit;
  logic [KEY_W-1:0]     in_key;
  logic [TREQ_W-1:0]    in_time;
  mode_e                in_mode;
  tbl_req_t             tbl_req;
  tbl_rsp_t             tbl_rsp;

  kstm_table u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (tbl_req),
    .rsp_o  (tbl_rsp)
  );

  assign in_key        = s_axis_tdata[KEY_W-1:0];
  assign in_time       = s_axis_tdata[KEY_W +: TREQ_W];
  assign in_mode       = mode_e'(s_axis_tuser);
  assign s_axis_tready = (st_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign pready  = 1'b1;
  assign apb_hit = (paddr[APB_AW-1:2] == REG_COMBO_WINDOW);
  assign prdata  = apb_hit ? APB_DW'(win_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (psel && penable && pwrite && pready && apb_hit) begin
      win_q <= WIN_W'(pwdata);
    end
  end

  always_comb begin
    evt_t                 ev;
    hold_t                hd;
    logic [TIME_BITS-1:0] gap;
    logic                 in_win;
    logic                 key_ok;
    st_d    = st_q;
    wk_d    = wk_q;
    ptot_d  = ptot_q;
    rtot_d  = rtot_q;
    res_d   = res_q;
    tbl_req = '0;
    plog_we = 1'b0;
    rlog_we = 1'b0;
    m_load  = 1'b0;
    ev      = tbl_rsp.evt;
    hd      = tbl_rsp.hold;
    gap     = time_q - hd.last;
    in_win  = CMP_W'(gap) <= CMP_W'(win_q);
    key_ok  = {1'b0, key_q} < (KEY_W + 1)'(NUM_KEYS);
    case (st_q)
      S_IDLE: begin
        if (s_acc) begin
          if (in_mode == MODE_FRAME) begin
            wk_d = '0;
            if (ptot_q < PCW'(MAX_PRESSED) && rtot_q < RCW'(MAX_RELEASED)) begin
              st_d = S_CLR_P;
            end else begin
              st_d = S_CLR_ALL;
            end
          end else begin
            tbl_req.re    = 1'b1;
            tbl_req.raddr = in_key[KIW-1:0];
            st_d          = S_MOD;
          end
        end
      end
      S_CLR_P: begin
        if (wk_q < WKW'(ptot_q)) begin
          tbl_req.waddr          = plog_q[wk_q[PLW-1:0]][KIW-1:0];
          tbl_req.evt_we.pressed = 1'b1;
          wk_d                   = wk_q + WKW'(1);
        end else begin
          wk_d = '0;
          st_d = S_CLR_R;
        end
      end
      S_CLR_R: begin
        if (wk_q < WKW'(rtot_q)) begin
          tbl_req.waddr           = rlog_q[wk_q[RLW-1:0]][KIW-1:0];
          tbl_req.evt_we.released = 1'b1;
          wk_d                    = wk_q + WKW'(1);
        end else begin
          st_d = S_FRD;
        end
      end
      S_CLR_ALL: begin
        tbl_req.waddr  = wk_q[KIW-1:0];
        tbl_req.evt_we = '1;
        if (wk_q == WKW'(NUM_KEYS - 1)) begin
          st_d = S_FRD;
        end else begin
          wk_d = wk_q + WKW'(1);
        end
      end
      S_FRD: begin
        tbl_req.re    = 1'b1;
        tbl_req.raddr = key_q[KIW-1:0];
        ptot_d        = '0;
        rtot_d        = '0;
        st_d          = S_MOD;
      end
      S_MOD: begin
        if (key_ok && (mode_q == MODE_PRESS || mode_q == MODE_RELEASE)) begin
          if (mode_q == MODE_PRESS) begin
            if (!ev.pressed && !hd.down) begin
              if (ptot_q < PCW'(MAX_PRESSED)) begin
                plog_we = 1'b1;
                ptot_d  = ptot_q + PCW'(1);
              end
              ev.pressed = 1'b1;
            end
            hd.down = 1'b1;
            hd.up   = 1'b0;
            if (!in_win) begin
              hd.tap = TAP_W'(1);
            end else if (hd.tap != '1) begin
              hd.tap = hd.tap + TAP_W'(1);
            end
            hd.last = time_q;
          end else begin
            if (!ev.released && !hd.up) begin
              if (rtot_q < RCW'(MAX_RELEASED)) begin
                rlog_we = 1'b1;
                rtot_d  = rtot_q + RCW'(1);
              end
              ev.released = 1'b1;
            end
            hd.up   = 1'b1;
            hd.down = 1'b0;
          end
          tbl_req.waddr   = key_q[KIW-1:0];
          tbl_req.evt_we  = '1;
          tbl_req.evt_wd  = ev;
          tbl_req.hold_we = 1'b1;
          tbl_req.hold_wd = hd;
          tbl_req.vld_set = 1'b1;
        end
        if (!key_ok) begin
          ev = '0;
          hd = '0;
        end
        res_d = {CNT_OUT_W'(rtot_d), CNT_OUT_W'(ptot_d), hd.up, hd.down,
                 ev.released, ev.pressed, hd.tap};
        st_d  = S_OUT;
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_load = 1'b1;
          st_d   = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      wk_q      <= '0;
      ptot_q    <= '0;
      rtot_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      wk_q   <= wk_d;
      ptot_q <= ptot_d;
      rtot_q <= rtot_d;
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mode_q <= in_mode;
      key_q  <= in_key;
      time_q <= TIME_BITS'(in_time);
    end
    if (plog_we) begin
      plog_q[ptot_q[PLW-1:0]] <= key_q;
    end
    if (rlog_we) begin
      rlog_q[rtot_q[RLW-1:0]] <= key_q;
    end
    res_q <= res_d;
    if (m_load) begin
      m_data_q <= res_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(m_data_q);

  `KSTM_ASSERT_IMP(a_tot_bound, clk_i, rst_ni, 1'b1,
    (ptot_q <= PCW'(MAX_PRESSED)) && (rtot_q <= RCW'(MAX_RELEASED)),
    "log count beyond capacity")
  `KSTM_ASSERT_IMP(a_walk_no_overflow, clk_i, rst_ni,
    (st_q == S_CLR_P) || (st_q == S_CLR_R),
    (ptot_q < PCW'(MAX_PRESSED)) && (rtot_q < RCW'(MAX_RELEASED)),
    "log walk entered with a full log")
  `KSTM_ASSERT_IMP(a_no_rw_clash, clk_i, rst_ni, tbl_req.re,
    !tbl_req.hold_we && !tbl_req.evt_we.pressed && !tbl_req.evt_we.released,
    "table read and write in the same cycle")
  `KSTM_ASSERT_NXT(a_mod_to_out, clk_i, rst_ni, st_q == S_MOD, st_q == S_OUT,
    "update not followed by result")

endmodule

@@ dv/kstm_report_checker.sv @@
// Result checker for the key state tracker: watches the input, result and APB channels,
// keeps its own key table, logs and tap window, and compares every result beat.
// Depends on kstm_pkg.
module kstm_report_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  input  logic                            s_ready_i,
  input  logic [kstm_pkg::S_TDATA_W-1:0]  s_data_i,
  input  logic [kstm_pkg::MODE_W-1:0]     s_user_i,
  input  logic                            m_valid_i,
  input  logic                            m_ready_i,
  input  logic [kstm_pkg::M_TDATA_W-1:0]  m_data_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [kstm_pkg::APB_AW-1:0]     paddr_i,
  input  logic [kstm_pkg::APB_DW-1:0]     pwdata_i,
  input  logic                            pready_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import kstm_pkg::*;

  typedef struct packed {
    logic [TAP_W-1:0]     combo;
    logic                 pressed;
    logic                 released;
    logic                 down;
    logic                 up;
    logic [CNT_OUT_W-1:0] pcnt;
    logic [CNT_OUT_W-1:0] rcnt;
  } key_report_t;

  logic                 is_pressed  [NUM_KEYS];
  logic                 is_released [NUM_KEYS];
  logic                 is_down     [NUM_KEYS];
  logic                 is_up       [NUM_KEYS];
  logic [TREQ_W-1:0]    last_tick   [NUM_KEYS];
  logic [TAP_W-1:0]     taps        [NUM_KEYS];
  logic [KEY_W-1:0]     press_log   [MAX_PRESSED];
  logic [KEY_W-1:0]     rel_log     [MAX_RELEASED];
  int                   press_fill;
  int                   rel_fill;
  logic [WIN_W-1:0]     window;
  key_report_t          report_q[$];
  int                   errs;

  assign fail_count_o = errs;

  function automatic key_report_t track_item(mode_e m, logic [KEY_W-1:0] k,
                                             logic [TREQ_W-1:0] t);
    key_report_t r;
    logic [TREQ_W-1:0] gap;
    if (m == MODE_PRESS) begin
      if (!is_pressed[k] && !is_down[k]) begin
        if (press_fill < MAX_PRESSED) begin
          press_log[press_fill] = k;
          press_fill++;
        end
        is_pressed[k] = 1'b1;
      end
      is_down[k] = 1'b1;
      is_up[k] = 1'b0;
      gap = t - last_tick[k];
      if (gap <= window) begin
        if (taps[k] != 8'hFF) taps[k] = taps[k] + 8'd1;
      end else begin
        taps[k] = 8'd1;
      end
      last_tick[k] = t;
    end else if (m == MODE_RELEASE) begin
      if (!is_released[k] && !is_up[k]) begin
        if (rel_fill < MAX_RELEASED) begin
          rel_log[rel_fill] = k;
          rel_fill++;
        end
        is_released[k] = 1'b1;
      end
      is_up[k] = 1'b1;
      is_down[k] = 1'b0;
    end else if (m == MODE_FRAME) begin
      if (press_fill < MAX_PRESSED && rel_fill < MAX_RELEASED) begin
        for (int i = 0; i < press_fill; i++) is_pressed[press_log[i]] = 1'b0;
        for (int i = 0; i < rel_fill; i++) is_released[rel_log[i]] = 1'b0;
      end else begin
        for (int i = 0; i < NUM_KEYS; i++) begin
          is_pressed[i] = 1'b0;
          is_released[i] = 1'b0;
        end
      end
      press_fill = 0;
      rel_fill = 0;
    end
    r.combo    = taps[k];
    r.pressed  = is_pressed[k];
    r.released = is_released[k];
    r.down     = is_down[k];
    r.up       = is_up[k];
    r.pcnt     = CNT_OUT_W'(press_fill);
    r.rcnt     = CNT_OUT_W'(rel_fill);
    return r;
  endfunction

  function automatic int field_differs(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    key_report_t want;
    key_report_t got;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        is_pressed[i] = 1'b0;
        is_released[i] = 1'b0;
        is_down[i] = 1'b0;
        is_up[i] = 1'b0;
        last_tick[i] = '0;
        taps[i] = '0;
      end
      press_fill = 0;
      rel_fill = 0;
      window = '0;
      report_q.delete();
      errs = 0;
      pending_o <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_AW-1:2] == REG_COMBO_WINDOW) begin
        window = pwdata_i[WIN_W-1:0];
      end
      if (m_valid_i && m_ready_i) begin
        if (report_q.size() == 0) begin
          $error("result beat arrived with no item waiting");
          errs++;
        end else begin
          want = report_q.pop_front();
          got.combo    = m_data_i[7:0];
          got.pressed  = m_data_i[8];
          got.released = m_data_i[9];
          got.down     = m_data_i[10];
          got.up       = m_data_i[11];
          got.pcnt     = m_data_i[16:12];
          got.rcnt     = m_data_i[21:17];
          errs += field_differs("combo", want.combo, got.combo);
          errs += field_differs("pressed", 8'(want.pressed), 8'(got.pressed));
          errs += field_differs("released", 8'(want.released), 8'(got.released));
          errs += field_differs("down", 8'(want.down), 8'(got.down));
          errs += field_differs("up", 8'(want.up), 8'(got.up));
          errs += field_differs("pressed_count", 8'(want.pcnt), 8'(got.pcnt));
          errs += field_differs("released_count", 8'(want.rcnt), 8'(got.rcnt));
        end
      end
      if (s_valid_i && s_ready_i) begin
        report_q.push_back(track_item(mode_e'(s_user_i), s_data_i[KEY_W-1:0],
                                      s_data_i[KEY_W +: TREQ_W]));
      end
      pending_o <= report_q.size();
    end
  end

endmodule

@@ dv/tb_key_state_tracker_multitap_unit.sv @@
// Top of the key state tracker testbench: clock, reset, directed and random beats,
// tap window writes over APB, and the verdict.
// Depends on kstm_pkg, kstm_report_checker and key_state_tracker_multitap_unit.
module tb_key_state_tracker_multitap_unit;
  import kstm_pkg::*;

  localparam int LIMIT = 1000000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_valid;
  logic                  s_ready;
  logic [S_TDATA_W-1:0]  s_data;
  logic [MODE_W-1:0]     s_user;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [M_TDATA_W-1:0]  m_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_AW-1:0]     paddr;
  logic [APB_DW-1:0]     pwdata;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;
  logic                  calm;
  logic [TREQ_W-1:0]     tick;
  int                    fails;
  int                    pending;
  int                    cycles = 0;

  key_state_tracker_multitap_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  kstm_report_checker u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_valid),
    .s_ready_i    (s_ready),
    .s_data_i     (s_data),
    .s_user_i     (s_user),
    .m_valid_i    (m_valid),
    .m_ready_i    (m_ready),
    .m_data_i     (m_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_ready <= calm || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_beat(input mode_e m, input logic [KEY_W-1:0] k,
                           input logic [TREQ_W-1:0] t);
    if (!calm && $urandom_range(0, 99) < 18) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= m;
    s_data  <= {t, k};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] v);
    s_valid <= 1'b0;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_COMBO_WINDOW, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly presses, releases and queries over a pool of keys with frame ends between, and some noise beats.
  task automatic run_phase(input int n, input int key_span, input int frame_pct,
                           input int press_pct, input int step_max, input int hot_pct);
    mode_e             m;
    logic [KEY_W-1:0]  k;
    logic [TREQ_W-1:0] t;
    int                r;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 10) begin
        m = mode_e'($urandom_range(0, 3));
        k = KEY_W'($urandom());
        t = $urandom();
      end else begin
        if ($urandom_range(0, 99) < frame_pct) begin
          m = MODE_FRAME;
        end else begin
          r = $urandom_range(0, 99);
          if (r < press_pct) m = MODE_PRESS;
          else if (r < press_pct + (100 - press_pct) * 3 / 4) m = MODE_RELEASE;
          else m = MODE_QUERY;
        end
        if ($urandom_range(0, 99) < hot_pct) k = KEY_W'(7);
        else k = KEY_W'($urandom_range(0, key_span - 1));
        if ($urandom_range(0, 99) < 5) begin
          t = $urandom();
        end else begin
          tick = tick + TREQ_W'($urandom_range(0, step_max));
          t = tick;
        end
      end
      send_beat(m, k, t);
    end
  endtask

  initial begin
    rst_ni  = 1'b0;
    s_valid = 1'b0;
    s_user  = '0;
    s_data  = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    calm    = 1'b0;
    tick    = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(MODE_QUERY, 8'd0, 32'd0);
    send_beat(MODE_PRESS, 8'd0, 32'd0);
    send_beat(MODE_PRESS, 8'd0, 32'd0);
    send_beat(MODE_RELEASE, 8'd0, 32'd0);
    send_beat(MODE_RELEASE, 8'd0, 32'd0);
    send_beat(MODE_PRESS, 8'd255, 32'hFFFF_FFFF);
    write_window(32'd1);
    send_beat(MODE_PRESS, 8'd255, 32'd0);
    send_beat(MODE_QUERY, 8'd255, 32'hFFFF_FFFF);
    send_beat(MODE_FRAME, 8'd0, 32'd0);
    for (int k = 16; k <= 32; k++) send_beat(MODE_PRESS, KEY_W'(k), 32'd100);
    send_beat(MODE_RELEASE, 8'd40, 32'd100);
    send_beat(MODE_FRAME, 8'd16, 32'd100);

    write_window($urandom_range(1, 40));
    run_phase(200, 24, 8, 45, 60, 0);

    write_window($urandom());
    calm <= 1'b1;
    run_phase(150, 256, 2, 50, 32'h7FFF_FFFF, 0);
    calm <= 1'b0;

    write_window(32'd0);
    run_phase(150, 12, 8, 45, 2, 0);

    write_window(32'hFFFF_FFFF);
    run_phase(220, 256, 1, 95, 1000, 95);
    s_valid <= 1'b0;

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fails == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
